/* hw/rtl/bpdms_pkg.sv */
// ----------------------------------------------------------------------------
// bpdms_pkg
// Shared types and constants for the button debouncer and mode stepper.
// ----------------------------------------------------------------------------
package bpdms_pkg;

  // history depth and length of a stable run
  localparam int HISTORY_BITS = 64;
  localparam int STABLE_RUN   = 20;

  // field widths
  localparam int MODE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int IN_W    = 8;
  localparam int OUT_W   = 16;

  // history patterns
  localparam logic [HISTORY_BITS-1:0] HIST_MASK = '1;
  localparam logic [HISTORY_BITS-1:0] RUN_PATTERN =
    (STABLE_RUN >= HISTORY_BITS) ? HIST_MASK : (HIST_MASK >> (HISTORY_BITS - STABLE_RUN));
  localparam logic [HISTORY_BITS-1:0] RELEASE_PATTERN =
    (STABLE_RUN >= HISTORY_BITS) ? HIST_MASK : (HIST_MASK << (HISTORY_BITS - STABLE_RUN));

  // register indexes
  localparam logic [IDX_W-1:0] REG_NUM_ROUTINES   = 2'd0;
  localparam logic [IDX_W-1:0] REG_STEP_THRESHOLD = 2'd1;
  localparam logic [IDX_W-1:0] REG_OFF_THRESHOLD  = 2'd2;

  // register reset values
  localparam logic [MODE_W-1:0]  NUM_ROUTINES_RST   = 8'd1;
  localparam logic [COUNT_W-1:0] STEP_THRESHOLD_RST = 16'd200;
  localparam logic [COUNT_W-1:0] OFF_THRESHOLD_RST  = 16'd1000;

  // press event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RELEASE = 2'd1,
    EV_PRESS   = 2'd2,
    EV_HELD    = 2'd3
  } event_t;

  // matched request handed from the matcher to the stepper
  typedef struct packed {
    logic   valid;
    event_t ev;
  } match_t;

  // configuration seen by the stepper
  typedef struct packed {
    logic [MODE_W-1:0]  num_routines;
    logic [COUNT_W-1:0] step_threshold;
    logic [COUNT_W-1:0] off_threshold;
    logic               mode_clear;
  } step_cfg_t;

endpackage

/* hw/rtl/bpdms_matcher.sv */
// ----------------------------------------------------------------------------
// bpdms_matcher
// Sample history shift register and exact pattern match, registered event.
// ----------------------------------------------------------------------------
module bpdms_matcher (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              pin_level,
  input  logic              advance,
  output bpdms_pkg::match_t match
);

  logic [bpdms_pkg::HISTORY_BITS-1:0] history;
  logic [bpdms_pkg::HISTORY_BITS-1:0] history_next;
  bpdms_pkg::event_t                  ev_next;
  logic                               valid;
  bpdms_pkg::event_t                  ev;

  // shift in the new sample, release tested first
  always_comb begin
    history_next = {history[bpdms_pkg::HISTORY_BITS-2:0], pin_level};
    if (history_next == bpdms_pkg::RELEASE_PATTERN) begin
      ev_next = bpdms_pkg::EV_RELEASE;
    end else if (history_next == bpdms_pkg::RUN_PATTERN) begin
      ev_next = bpdms_pkg::EV_PRESS;
    end else if (history_next == bpdms_pkg::HIST_MASK) begin
      ev_next = bpdms_pkg::EV_HELD;
    end else begin
      ev_next = bpdms_pkg::EV_NONE;
    end
  end

  // history and request valid
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      valid   <= 1'b0;
    end else begin
      if (accept) begin
        history <= history_next;
        valid   <= 1'b1;
      end else if (advance) begin
        valid   <= 1'b0;
      end
    end
  end

  // event payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ev <= ev_next;
    end
  end

  assign match.valid = valid;
  assign match.ev    = ev;

endmodule

/* hw/rtl/bpdms_stepper.sv */
// ----------------------------------------------------------------------------
// bpdms_stepper
// Press counter, mode index stepping and the result register.
// ----------------------------------------------------------------------------
module bpdms_stepper (
  input  logic                                clk,
  input  logic                                rst,
  input  bpdms_pkg::match_t                   match,
  input  logic                                advance,
  input  logic                                out_take,
  input  bpdms_pkg::step_cfg_t                cfg,
  output logic                                out_valid,
  output bpdms_pkg::event_t                   out_event,
  output logic [bpdms_pkg::MODE_W-1:0]        out_mode,
  output logic                                out_pdown,
  output logic [bpdms_pkg::MODE_W-1:0]        mode_reg
);

  logic [bpdms_pkg::COUNT_W-1:0] press_count;
  logic [bpdms_pkg::COUNT_W-1:0] press_count_next;
  logic [bpdms_pkg::COUNT_W-1:0] count_inc;
  logic [bpdms_pkg::MODE_W-1:0]  mode_next;
  logic [bpdms_pkg::MODE_W:0]    fwd_sum;
  logic [bpdms_pkg::MODE_W:0]    bwd_sum;
  logic [bpdms_pkg::MODE_W:0]    n_ext;
  logic [bpdms_pkg::MODE_W-1:0]  mode_fwd;
  logic [bpdms_pkg::MODE_W-1:0]  mode_bwd;
  logic                          pdown_next;

  // wrapped forward and backward steps, mode stays below num_routines (zero when num_routines is zero)
  always_comb begin
    n_ext   = {1'b0, cfg.num_routines};
    fwd_sum = {1'b0, mode_reg} + 9'd1;
    bwd_sum = {1'b0, mode_reg} + n_ext - 9'd1;
    if (cfg.num_routines == '0) begin
      mode_fwd = '0;
      mode_bwd = '0;
    end else begin
      mode_fwd = (fwd_sum >= n_ext) ? bpdms_pkg::MODE_W'(fwd_sum - n_ext)
                                    : fwd_sum[bpdms_pkg::MODE_W-1:0];
      mode_bwd = (bwd_sum >= n_ext) ? bpdms_pkg::MODE_W'(bwd_sum - n_ext)
                                    : bwd_sum[bpdms_pkg::MODE_W-1:0];
    end
  end

  // counter and mode update for one request
  always_comb begin
    count_inc        = press_count + 16'd1;
    press_count_next = press_count;
    mode_next        = mode_reg;
    pdown_next       = 1'b0;
    case (match.ev)
      bpdms_pkg::EV_RELEASE: begin
        if (press_count > cfg.step_threshold) begin
          mode_next = mode_fwd;
        end else if (press_count != '0) begin
          mode_next = mode_bwd;
        end
        press_count_next = '0;
      end
      bpdms_pkg::EV_PRESS: begin
        press_count_next = 16'd1;
      end
      bpdms_pkg::EV_HELD: begin
        if (count_inc > cfg.off_threshold) begin
          press_count_next = '0;
          pdown_next       = 1'b1;
        end else begin
          press_count_next = count_inc;
        end
      end
      default: begin
        press_count_next = press_count;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      press_count <= '0;
      mode_reg    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.mode_clear) begin
        mode_reg <= '0;
      end else if (advance) begin
        mode_reg <= mode_next;
      end
      if (advance) begin
        press_count <= press_count_next;
        out_valid   <= 1'b1;
      end else if (out_take) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= match.ev;
      out_mode  <= mode_next;
      out_pdown <= pdown_next;
    end
  end

endmodule

/* hw/rtl/button_press_debouncer_mode_stepper_core.sv */
// ----------------------------------------------------------------------------
// button_press_debouncer_mode_stepper_core
// Path: an accepted sample passes the matcher register, then the stepper result register.
// Throughput: one sample per cycle while the master side takes results; the matcher and stepper registers pipeline it.
// Reset (rst, synchronous): history, press count and mode cleared, registers
// back to their defaults (1, 200, 1000), no result pending.
// ----------------------------------------------------------------------------
module button_press_debouncer_mode_stepper_core (
  input  logic                            clk,
  input  logic                            rst,
  // sample stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bpdms_pkg::IN_W-1:0]      s_tdata,   // [0] pin_level, [7:1] zero
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bpdms_pkg::OUT_W-1:0]     m_tdata,   // [1:0] press_event,
                                                     // [9:2] mode_index,
                                                     // [10] power_down, [15:11] zero
  // configuration writes
  input  logic                            cfg_we,
  input  logic [bpdms_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bpdms_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [bpdms_pkg::MODE_W-1:0]  num_routines;
  logic [bpdms_pkg::COUNT_W-1:0] step_threshold;
  logic [bpdms_pkg::COUNT_W-1:0] off_threshold;
  bpdms_pkg::step_cfg_t          step_cfg;
  bpdms_pkg::match_t             match;
  bpdms_pkg::event_t             out_event;
  logic [bpdms_pkg::MODE_W-1:0]  out_mode;
  logic [bpdms_pkg::MODE_W-1:0]  mode_reg;
  logic                          out_pdown;
  logic                          out_valid;
  logic                          stage_ready;
  logic                          advance;
  logic                          accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_routines   <= bpdms_pkg::NUM_ROUTINES_RST;
      step_threshold <= bpdms_pkg::STEP_THRESHOLD_RST;
      off_threshold  <= bpdms_pkg::OFF_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpdms_pkg::REG_NUM_ROUTINES:   num_routines   <= cfg_wdata[bpdms_pkg::MODE_W-1:0];
        bpdms_pkg::REG_STEP_THRESHOLD: step_threshold <= cfg_wdata;
        bpdms_pkg::REG_OFF_THRESHOLD:  off_threshold  <= cfg_wdata;
        default: begin
          num_routines <= num_routines;
        end
      endcase
    end
  end

  assign step_cfg.num_routines   = num_routines;
  assign step_cfg.step_threshold = step_threshold;
  assign step_cfg.off_threshold  = off_threshold;
  assign step_cfg.mode_clear     = cfg_we && (cfg_index == bpdms_pkg::REG_NUM_ROUTINES);

  // pipeline handshake
  assign stage_ready = !out_valid || m_tready;
  assign advance     = match.valid && stage_ready;
  assign s_tready    = !match.valid || stage_ready;
  assign accept      = s_tvalid && s_tready;

  bpdms_matcher u_matcher (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pin_level (s_tdata[0]),
    .advance   (advance),
    .match     (match)
  );

  bpdms_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .match     (match),
    .advance   (advance),
    .out_take  (m_tready),
    .cfg       (step_cfg),
    .out_valid (out_valid),
    .out_event (out_event),
    .out_mode  (out_mode),
    .out_pdown (out_pdown),
    .mode_reg  (mode_reg)
  );

  // result packing
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_pdown, out_mode, out_event};

  // power-down only comes with a held event
  a_pdown_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pdown) |-> (out_event == bpdms_pkg::EV_HELD))
    else $error("power-down without held event");

  // mode index stays within the configured mode count
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    (num_routines != '0) |-> (mode_reg < num_routines))
    else $error("mode index out of range");

  // sample side never stalls while no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("sample side stalled with empty output");

  // a result appears the cycle after the stepper takes a request
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("request taken without result");

endmodule
